// ----- src/assert_macros.svh -----
// Assertion macros shared by the translator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/kst_pkg.sv -----
// Shared types and constants of the scan code translator.
package kst_pkg;

  localparam int SCAN_CODES_DEFAULT  = 256;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int HOTKEY_W = 25;

  localparam logic REG_RESET_HOTKEY  = 1'b0;
  localparam logic REG_LAYOUT_HOTKEY = 1'b1;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [7:0] SCAN_CTRL   = 8'h1d;
  localparam logic [7:0] SCAN_ALT    = 8'h38;
  localparam logic [7:0] SCAN_LSHIFT = 8'h2a;
  localparam logic [7:0] SCAN_RSHIFT = 8'h36;
  localparam logic [7:0] SCAN_F4     = 8'h3e;

  localparam logic [HOTKEY_W-1:0] CLEAR_KEY = 25'h0010177;

  localparam logic [2:0] PRESS_MAX   = 3'd7;
  localparam logic [2:0] PRESS_LIMIT = 3'd3;

  typedef struct packed {
    logic [15:0]         code;
    logic [HOTKEY_W-1:0] packed_key;
    logic                rst_req;
    logic                tog;
    logic                clr;
    logic                emit;
  } kst_entry_t;

endpackage

// ----- src/keyboard_scan_code_translator_core.sv -----
// Top level of the set-1 scan code translator.
//
//   channel   handshake            payload
//   input     in_valid/in_stall    kind, scan_code, extended, pressed, emit_bytes,
//                                  write_layout, write_modifiers, write_code
//   output    out_valid/out_stall  out_byte, byte_valid, last, packed_key,
//                                  reset_request, layout_toggled, clear_request
//   config    cfg_write            cfg_index, cfg_data
//
// An item is taken every cycle while in_stall is low; a key press gives one or two
// output beats, one per cycle while out_stall is low, via the table read stage, the
// queue and the output register. After reset the key table is cleared one entry a
// cycle, all 16 * SCAN_CODES entries, while in_stall is high.
// The decoded-press queue holds QUEUE_DEPTH entries; output stalls reach the input only
// once in_stall rises, when its level plus the table read stage press reach QUEUE_DEPTH.
module keyboard_scan_code_translator_core import kst_pkg::*; #(
  parameter int SCAN_CODES  = SCAN_CODES_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [HOTKEY_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [7:0]          scan_code,
  input  logic                extended,
  input  logic                pressed,
  input  logic                emit_bytes,
  input  logic                write_layout,
  input  logic [1:0]          write_modifiers,
  input  logic [15:0]         write_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                last,
  output logic [HOTKEY_W-1:0] packed_key,
  output logic                reset_request,
  output logic                layout_toggled,
  output logic                clear_request
);

  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic               push;
  kst_entry_t         push_entry;
  logic               pop;
  kst_entry_t         head;
  logic               head_valid;
  logic [LEVEL_W-1:0] level;

  kst_front #(
    .SCAN_CODES (SCAN_CODES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .scan_code      (scan_code),
    .extended       (extended),
    .pressed        (pressed),
    .emit_bytes     (emit_bytes),
    .write_layout   (write_layout),
    .write_modifiers(write_modifiers),
    .write_code     (write_code),
    .level          (level),
    .push           (push),
    .push_entry     (push_entry)
  );

  kst_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .level     (level)
  );

  kst_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .packed_key    (packed_key),
    .reset_request (reset_request),
    .layout_toggled(layout_toggled),
    .clear_request (clear_request)
  );

endmodule

// ----- src/kst_front.sv -----
// Front part: accepts items, tracks modifier state, owns the key table and hotkey compare.
`include "assert_macros.svh"

module kst_front import kst_pkg::*; #(
  parameter int SCAN_CODES  = SCAN_CODES_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [HOTKEY_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [7:0]          scan_code,
  input  logic                extended,
  input  logic                pressed,
  input  logic                emit_bytes,
  input  logic                write_layout,
  input  logic [1:0]          write_modifiers,
  input  logic [15:0]         write_code,
  input  logic [LEVEL_W-1:0]  level,
  output logic                push,
  output kst_entry_t          push_entry
);

  localparam int TABLE_DEPTH = 16 * SCAN_CODES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam logic [LEVEL_W:0] LEVEL_LIMIT = (LEVEL_W + 1)'(QUEUE_DEPTH);

  logic [15:0] key_table [TABLE_DEPTH];
  logic [15:0] rdata;

  logic [HOTKEY_W-1:0] reset_hotkey;
  logic [HOTKEY_W-1:0] layout_hotkey;
  logic                ctrl_held;
  logic                shift_held;
  logic                active_layout;
  logic [2:0]          press_count;
  logic                clearing;
  logic [ADDR_W-1:0]   clear_addr;

  logic                s1_valid;
  logic                s1_in_range;
  logic [HOTKEY_W-1:0] s1_packed;
  logic                s1_rst_req;
  logic                s1_tog;
  logic                s1_clr;
  logic                s1_emit;

  logic                accept;
  logic                in_range;
  logic                is_ctrl;
  logic                is_shift;
  logic                swallow;
  logic                key_press;
  logic                tbl_write;
  logic [3:0]          row;
  logic [ADDR_W-1:0]   addr;
  logic [HOTKEY_W-1:0] packed_now;
  logic [2:0]          press_inc;
  logic                hit_reset;
  logic                hit_layout;
  logic                hit_clear;

  assign in_stall = clearing || (({1'b0, level} + (LEVEL_W + 1)'(s1_valid)) >= LEVEL_LIMIT);
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, scan_code} < 9'(SCAN_CODES);

  assign is_ctrl   = (scan_code == SCAN_CTRL) || (scan_code == SCAN_ALT);
  assign is_shift  = ((scan_code == SCAN_LSHIFT) || (scan_code == SCAN_RSHIFT)) && !extended;
  assign swallow   = (scan_code == SCAN_F4) && !extended && ctrl_held && shift_held;
  assign key_press = accept && (kind == KIND_KEY) && !is_ctrl && !is_shift && pressed
                     && !swallow;
  assign tbl_write = accept && (kind == KIND_WRITE) && in_range;

  always_comb begin
    if (kind == KIND_WRITE) begin
      row = {extended, write_layout, write_modifiers};
    end else begin
      row = {extended, active_layout ^ ctrl_held, ctrl_held, shift_held};
    end
  end

  assign addr = ADDR_W'(row) * ADDR_W'(SCAN_CODES) + ADDR_W'(scan_code);

  assign packed_now = {ctrl_held, 7'd0, shift_held, 7'd0, extended, scan_code};
  assign press_inc  = (press_count != PRESS_MAX) ? press_count + 3'd1 : press_count;
  assign hit_reset  = packed_now == reset_hotkey;
  assign hit_layout = !hit_reset && (packed_now == layout_hotkey);
  assign hit_clear  = !hit_reset && !hit_layout
                      && ((packed_now == CLEAR_KEY) || (press_inc > PRESS_LIMIT));

  always_ff @(posedge clk) begin
    if (clearing) begin
      key_table[clear_addr] <= '0;
    end else if (tbl_write) begin
      key_table[addr] <= write_code;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= key_table[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_hotkey  <= '0;
      layout_hotkey <= '0;
      ctrl_held     <= 1'b0;
      shift_held    <= 1'b0;
      active_layout <= 1'b1;
      press_count   <= '0;
      clearing      <= 1'b1;
      clear_addr    <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RESET_HOTKEY:  reset_hotkey  <= cfg_data;
          REG_LAYOUT_HOTKEY: layout_hotkey <= cfg_data;
          default:           reset_hotkey  <= reset_hotkey;
        endcase
      end
      if (clearing) begin
        if (clear_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clear_addr <= clear_addr + 1'b1;
      end
      if (accept && (kind == KIND_KEY)) begin
        if (is_ctrl) begin
          ctrl_held <= pressed;
        end else if (is_shift) begin
          shift_held <= pressed;
        end
      end
      if (key_press) begin
        press_count <= hit_clear ? 3'd0 : press_inc;
        if (hit_layout) begin
          active_layout <= !active_layout;
        end
      end
      s1_valid <= key_press;
    end
  end

  always_ff @(posedge clk) begin
    if (key_press) begin
      s1_in_range <= in_range;
      s1_packed   <= packed_now;
      s1_rst_req  <= hit_reset;
      s1_tog      <= hit_layout;
      s1_clr      <= hit_clear;
      s1_emit     <= emit_bytes;
    end
  end

  assign push                  = s1_valid;
  assign push_entry.code       = s1_in_range ? rdata : 16'd0;
  assign push_entry.packed_key = s1_packed;
  assign push_entry.rst_req    = s1_rst_req;
  assign push_entry.tog        = s1_tog;
  assign push_entry.clr        = s1_clr;
  assign push_entry.emit       = s1_emit;

  `KST_ASSERT_NOW(a_no_press_while_clearing, clearing, !s1_valid && in_stall, "item during clear")

endmodule

// ----- src/kst_queue.sv -----
// Short queue of decoded key presses between the front and back parts.
`include "assert_macros.svh"

module kst_queue import kst_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
  localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kst_entry_t         push_entry,
  input  logic               pop,
  output kst_entry_t         head,
  output logic               head_valid,
  output logic [LEVEL_W-1:0] level
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  kst_entry_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;
  assign level      = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `KST_ASSERT_NOW(a_no_overflow, push && !pop, count < LEVEL_W'(QUEUE_DEPTH), "queue overflow")
  `KST_ASSERT_NOW(a_no_underflow, pop, count != '0, "queue underflow")

endmodule

// ----- src/kst_back.sv -----
// Back part: turns each queued key press into one or two output beats.
`include "assert_macros.svh"

module kst_back import kst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  kst_entry_t          head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                byte_valid,
  output logic                last,
  output logic [HOTKEY_W-1:0] packed_key,
  output logic                reset_request,
  output logic                layout_toggled,
  output logic                clear_request
);

  logic       second;
  logic       load;
  logic       hi_nz;
  logic       beat_last;
  logic [7:0] beat_byte;

  assign load      = head_valid && (!out_valid || !out_stall);
  assign hi_nz     = head.code[15:8] != 8'd0;
  assign beat_last = !head.emit || second || !hi_nz;
  assign pop       = load && beat_last;

  always_comb begin
    if (!head.emit) begin
      beat_byte = 8'd0;
    end else if (second || !hi_nz) begin
      beat_byte = head.code[7:0];
    end else begin
      beat_byte = head.code[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      second    <= !beat_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= beat_byte;
      byte_valid     <= head.emit;
      last           <= beat_last;
      packed_key     <= head.packed_key;
      reset_request  <= head.rst_req;
      layout_toggled <= head.tog;
      clear_request  <= head.clr;
    end
  end

  `KST_ASSERT_NEXT(a_low_follows_high, out_valid && !out_stall && !last, out_valid && last,
                   "low byte beat missing")

endmodule
